// ===== src/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES     = 32;
  localparam int MAX_PAYLOAD_BYTES = 4;
  localparam int REG_COUNT         = 8;
  localparam int REG_W             = 48;
  localparam int REG_IDX_W         = 3;
  localparam int ENTRY_W           = 12;
  localparam int ENTRIES_PER_WORD  = 4;
  localparam int IDX_W             = 5;
  localparam int CNT_W             = 3;
  localparam int RAW_W             = 32;

  // Start sequence
  localparam logic [7:0] SEQ_FIRST  = 8'd255;
  localparam logic [7:0] SEQ_SECOND = 8'd123;
  localparam logic [7:0] SEQ_THIRD  = 8'd10;

  // Start detector progress
  localparam logic [1:0] MATCH_NONE   = 2'd0;
  localparam logic [1:0] MATCH_FIRST  = 2'd1;
  localparam logic [1:0] MATCH_SECOND = 2'd2;
  localparam logic [1:0] MATCH_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_NEED_NEXT = 2'd0,
    ST_NO_MORE   = 2'd1,
    ST_NOTHING   = 2'd2,
    ST_BAD_ID    = 2'd3
  } status_t;

  // Result of the id match against the table
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } lookup_t;

  // One result item
  typedef struct packed {
    status_t          status;
    logic             reading_valid;
    logic [7:0]       sensor_id;
    logic [IDX_W-1:0] table_index;
    logic [RAW_W-1:0] raw_value;
    logic [7:0]       bad_id;
  } result_t;

endpackage

// ===== src/sfd_table.sv =====
// ----------------------------------------------------------------------------
// sfd_table
// Sensor table registers, parallel id match and id read of the active entry.
// ----------------------------------------------------------------------------
module sfd_table
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic [7:0]           match_byte,
  output lookup_t              lookup,
  input  logic [IDX_W-1:0]     emit_index,
  output logic [7:0]           emit_id
);

  logic [REG_W-1:0]   words [REG_COUNT];
  logic [ENTRY_W-1:0] entries [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] match;

  // Configuration words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        words[i] <= '0;
      end
    end else if (cfg_write) begin
      words[cfg_index] <= cfg_data;
    end
  end

  // Unpack entries and compare each against the byte
  for (genvar e = 0; e < TABLE_ENTRIES; e++) begin : g_entry
    assign entries[e] = words[e / ENTRIES_PER_WORD][ENTRY_W*(e % ENTRIES_PER_WORD) +: ENTRY_W];
    assign match[e]   = entries[e][11] && (entries[e][7:0] == match_byte);
  end

  // Lowest matching entry wins; count is clamped
  always_comb begin
    logic [CNT_W-1:0] cnt;
    lookup.hit   = 1'b0;
    lookup.index = '0;
    for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
      if (match[e]) begin
        lookup.hit   = 1'b1;
        lookup.index = IDX_W'(e);
      end
    end
    cnt = entries[lookup.index][10:8];
    lookup.count = (cnt > CNT_W'(MAX_PAYLOAD_BYTES)) ? CNT_W'(MAX_PAYLOAD_BYTES) : cnt;
  end

  assign emit_id = entries[emit_index][7:0];

endmodule

// ===== src/sfd_core.sv =====
// ----------------------------------------------------------------------------
// sfd_core
// Deframer state: start detector, payload assembly and result forming.
// ----------------------------------------------------------------------------
module sfd_core
  import sfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_in,
  input  lookup_t          lookup,
  input  logic [7:0]       emit_id,
  output logic [IDX_W-1:0] current_index,
  output result_t          result
);

  logic [1:0]       start_match_count, start_match_count_next;
  logic             frame_started, frame_started_next;
  logic             collecting, collecting_next;
  logic [CNT_W-1:0] bytes_left, bytes_left_next;
  logic [RAW_W-1:0] accumulator, accumulator_next;
  logic [IDX_W-1:0] current_index_next;

  // Next state and result for the byte in the input stage
  always_comb begin
    logic             seq_done;
    logic [CNT_W-1:0] left_dec;
    logic [4:0]       shamt;
    start_match_count_next = start_match_count;
    frame_started_next     = frame_started;
    collecting_next        = collecting;
    bytes_left_next        = bytes_left;
    accumulator_next       = accumulator;
    current_index_next     = current_index;
    result                 = '0;
    result.status          = ST_NOTHING;
    seq_done               = 1'b0;
    left_dec               = bytes_left - CNT_W'(1);
    shamt                  = {left_dec[1:0], 3'b000};

    // start detector; a mismatch holds the count
    if (start_match_count == MATCH_NONE && data_in == SEQ_FIRST) begin
      start_match_count_next = MATCH_FIRST;
    end else if (start_match_count == MATCH_FIRST && data_in == SEQ_SECOND) begin
      start_match_count_next = MATCH_SECOND;
    end else if (start_match_count == MATCH_SECOND && data_in == SEQ_THIRD) begin
      start_match_count_next = MATCH_NONE;
      frame_started_next     = 1'b1;
      result.status          = ST_NEED_NEXT;
      seq_done               = 1'b1;
    end

    if (!seq_done) begin
      if (frame_started) begin
        // id right after a start sequence
        frame_started_next = 1'b0;
        collecting_next    = lookup.hit;
        bytes_left_next    = lookup.hit ? lookup.count : '0;
        accumulator_next   = '0;
        if (lookup.hit) begin
          current_index_next = lookup.index;
          result.status      = ST_NEED_NEXT;
        end else begin
          result.status = ST_BAD_ID;
          result.bad_id = data_in;
        end
      end else if (collecting && bytes_left != '0) begin
        // big-endian payload byte
        accumulator_next = accumulator + ({{(RAW_W-8){1'b0}}, data_in} << shamt);
        bytes_left_next  = left_dec;
        result.status    = ST_NEED_NEXT;
      end else if (collecting) begin
        // emit, then take this byte as the next id
        result.reading_valid = 1'b1;
        result.table_index   = current_index;
        result.sensor_id     = emit_id;
        result.raw_value     = accumulator;
        collecting_next      = lookup.hit;
        bytes_left_next      = lookup.hit ? lookup.count : '0;
        accumulator_next     = '0;
        if (lookup.hit) begin
          current_index_next = lookup.index;
          result.status      = ST_NEED_NEXT;
        end else begin
          result.status = ST_NO_MORE;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_match_count <= MATCH_NONE;
      frame_started     <= 1'b0;
      collecting        <= 1'b0;
      bytes_left        <= '0;
      accumulator       <= '0;
      current_index     <= '0;
    end else if (step) begin
      start_match_count <= start_match_count_next;
      frame_started     <= frame_started_next;
      collecting        <= collecting_next;
      bytes_left        <= bytes_left_next;
      accumulator       <= accumulator_next;
      current_index     <= current_index_next;
    end
  end

  function automatic logic seq_done_chk(input logic [1:0] cnt, input logic [7:0] b);
    return cnt == MATCH_SECOND && b == SEQ_THIRD;
  endfunction

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= CNT_W'(MAX_PAYLOAD_BYTES))
    else $error("payload count above limit");

  a_match_unused: assert property (@(posedge clk) disable iff (rst)
    start_match_count != MATCH_UNUSED)
    else $error("start detector in unused state");

  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    step && !seq_done_chk(start_match_count, data_in) && frame_started && !lookup.hit
    |=> !collecting && bytes_left == '0)
    else $error("failed id did not clear collection");
`endif

endmodule

// ===== src/sensor_frame_deframer_top.sv =====
// A byte waits in the input stage until the result register is free, and its
// result is then registered. Throughput: one byte per cycle while the result
// side is ready; the input stage and the result register form a two-entry
// pipeline, so input is taken while a result waits. Reset: synchronous rst
// clears the table, the frame state and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
// sensor_frame_deframer_top
// Byte-serial telemetry deframer with a 32-entry sensor table.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_top
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 data_valid,
  output logic                 data_ready,
  input  logic [7:0]           data_byte,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [1:0]           status,
  output logic                 reading_valid,
  output logic [7:0]           sensor_id,
  output logic [IDX_W-1:0]     table_index,
  output logic [RAW_W-1:0]     raw_value,
  output logic [7:0]           bad_id
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic             advance;
  lookup_t          lookup;
  logic [7:0]       emit_id;
  logic [IDX_W-1:0] current_index;
  result_t          result_comb;
  result_t          result_q;

  assign advance    = in_full && (!result_valid || result_ready);
  assign data_ready = !in_full || advance;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (data_valid && data_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      in_byte <= data_byte;
    end
  end

  sfd_table u_table (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .match_byte (in_byte),
    .lookup     (lookup),
    .emit_index (current_index),
    .emit_id    (emit_id)
  );

  sfd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data_in       (in_byte),
    .lookup        (lookup),
    .emit_id       (emit_id),
    .current_index (current_index),
    .result        (result_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_comb;
    end
  end

  assign status        = result_q.status;
  assign reading_valid = result_q.reading_valid;
  assign sensor_id     = result_q.sensor_id;
  assign table_index   = result_q.table_index;
  assign raw_value     = result_q.raw_value;
  assign bad_id        = result_q.bad_id;

`ifndef SYNTHESIS
  a_reading_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && reading_valid |-> status == ST_NEED_NEXT || status == ST_NO_MORE)
    else $error("reading with wrong status");

  a_bad_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && bad_id != 8'd0 |-> status == ST_BAD_ID)
    else $error("bad id without error status");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_full && result_valid && !result_ready |-> !data_ready)
    else $error("input taken while pipeline full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_q))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/tb_sensor_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer_top
// Self-checking bench for the telemetry deframer. Every byte request that the
// block takes is run through an in-bench copy of the deframer. The predicted
// result is queued and compared field by field with the next result request.
// Traffic is a short directed part, then random frames and noise over several
// sensor tables, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer_top;
  import sfd_pkg::*;

  localparam int MAX_WAIT       = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_BYTES    = 240;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 data_valid;
  logic                 data_ready;
  logic [7:0]           data_byte;
  logic                 result_valid;
  logic                 result_ready;
  logic [1:0]           status;
  logic                 reading_valid;
  logic [7:0]           sensor_id;
  logic [IDX_W-1:0]     table_index;
  logic [RAW_W-1:0]     raw_value;
  logic [7:0]           bad_id;

  sensor_frame_deframer_top dut (.*);

  // Mirror of the sensor table and of the deframer state
  logic [REG_W-1:0] sensor_table [REG_COUNT];
  logic [REG_W-1:0] staged_words [REG_COUNT];
  logic [1:0]       seq_progress;
  bit               id_expected;
  bit               in_sensor;
  logic [CNT_W-1:0] payload_left;
  logic [RAW_W-1:0] partial_raw;
  logic [IDX_W-1:0] active_entry;

  result_t frame_results_due [$];
  int      mismatch_count = 0;
  int      bytes_sent     = 0;
  int      quiet_cycles   = 0;
  bit      send_pauses    = 0;
  bit      take_pauses    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [ENTRY_W-1:0] entry_word(input int e);
    return sensor_table[e / ENTRIES_PER_WORD][ENTRY_W * (e % ENTRIES_PER_WORD) +: ENTRY_W];
  endfunction

  // Lowest valid entry that holds this id, -1 when none does
  function automatic int find_sensor(input logic [7:0] id);
    logic [ENTRY_W-1:0] ent;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      ent = entry_word(e);
      if (ent[11] && ent[7:0] == id) return e;
    end
    return -1;
  endfunction

  // Count field, clamped to the widest payload
  function automatic int payload_bytes(input int e);
    logic [ENTRY_W-1:0] ent;
    ent = entry_word(e);
    return (ent[10:8] > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : int'(ent[10:8]);
  endfunction

  function automatic bit open_sensor(input logic [7:0] id);
    int e;
    e            = find_sensor(id);
    in_sensor    = 1'b0;
    payload_left = '0;
    partial_raw  = '0;
    if (e < 0) return 1'b0;
    active_entry = IDX_W'(e);
    payload_left = CNT_W'(payload_bytes(e));
    in_sensor    = 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t            r;
    logic [ENTRY_W-1:0] ent;
    r        = '0;
    r.status = ST_NOTHING;
    // start detector sees every byte; only the last start byte stops here
    if (seq_progress == MATCH_NONE && b == SEQ_FIRST) begin
      seq_progress = MATCH_FIRST;
    end else if (seq_progress == MATCH_FIRST && b == SEQ_SECOND) begin
      seq_progress = MATCH_SECOND;
    end else if (seq_progress == MATCH_SECOND && b == SEQ_THIRD) begin
      seq_progress = MATCH_NONE;
      id_expected  = 1'b1;
      r.status     = ST_NEED_NEXT;
      return r;
    end
    if (id_expected) begin
      id_expected = 1'b0;
      if (open_sensor(b)) begin
        r.status = ST_NEED_NEXT;
      end else begin
        r.status = ST_BAD_ID;
        r.bad_id = b;
      end
    end else if (in_sensor && payload_left != 0) begin
      // big-endian collect
      partial_raw  = partial_raw + (RAW_W'(b) << (8 * (int'(payload_left) - 1)));
      payload_left = payload_left - 1'b1;
      r.status     = ST_NEED_NEXT;
    end else if (in_sensor) begin
      // payload done: emit, then this byte is the next id
      ent             = entry_word(active_entry);
      r.reading_valid = 1'b1;
      r.table_index   = active_entry;
      r.sensor_id     = ent[7:0];
      r.raw_value     = partial_raw;
      r.status        = open_sensor(b) ? ST_NEED_NEXT : ST_NO_MORE;
    end
    return r;
  endfunction

  task automatic clear_model();
    for (int i = 0; i < REG_COUNT; i++) sensor_table[i] = '0;
    seq_progress = MATCH_NONE;
    id_expected  = 1'b0;
    in_sensor    = 1'b0;
    payload_left = '0;
    partial_raw  = '0;
    active_entry = '0;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Result side: random stall before each request, then compare
  initial begin : result_sink
    int      stall;
    result_t want;
    result_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = take_pauses ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (frame_results_due.size() == 0) begin
        report_mismatch("result request with nothing predicted");
      end else begin
        want = frame_results_due.pop_front();
        check_field("status", status, want.status);
        check_field("reading_valid", reading_valid, want.reading_valid);
        check_field("sensor_id", sensor_id, want.sensor_id);
        check_field("table_index", table_index, want.table_index);
        check_field("raw_value", raw_value, want.raw_value);
        check_field("bad_id", bad_id, want.bad_id);
      end
    end
  end

  // Watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sensor_frame_deframer_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_pauses ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    frame_results_due.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  // Sender holds off until every predicted result has been seen
  task automatic wait_for_results();
    data_valid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  // Writes all eight table words; only called with the block idle
  task automatic load_table();
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= staged_words[i];
      @(posedge clk);
      sensor_table[i] = staged_words[i];
    end
    cfg_write <= 1'b0;
  endtask

  task automatic stage_random_table(input int valid_pct);
    logic [ENTRY_W-1:0] ent;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      ent[11]   = $urandom_range(0, 99) < valid_pct;
      ent[10:8] = CNT_W'($urandom_range(0, 7));
      // mostly a small id pool so that hits and duplicates are common
      ent[7:0]  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 15) * 17);
      staged_words[e / ENTRIES_PER_WORD][ENTRY_W * (e % ENTRIES_PER_WORD) +: ENTRY_W] = ent;
    end
  endtask

  function automatic logic [7:0] pick_sensor_id();
    logic [ENTRY_W-1:0] ent;
    ent = entry_word($urandom_range(0, TABLE_ENTRIES - 1));
    if (ent[11] && $urandom_range(0, 7) != 0) return ent[7:0];
    return 8'($urandom_range(0, 255));
  endfunction

  // Start sequence, a chain of sensors with random payload, then a closing byte; an id that misses ends the frame early
  task automatic send_frame();
    int         links;
    int         e;
    logic [7:0] id;
    send_byte(SEQ_FIRST);
    send_byte(SEQ_SECOND);
    send_byte(SEQ_THIRD);
    links = $urandom_range(1, 4);
    for (int k = 0; k < links; k++) begin
      id = pick_sensor_id();
      send_byte(id);
      e = find_sensor(id);
      if (e < 0) return;
      repeat (payload_bytes(e)) send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stray bytes and broken start sequences
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: send_byte(SEQ_FIRST);
        1: send_byte(SEQ_SECOND);
        2: send_byte(SEQ_THIRD);
        3: begin
          send_byte(SEQ_FIRST);
          send_byte(SEQ_SECOND);
        end
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests
  // Empty table after reset: idle byte, then an id of zero after a start
  task automatic test_unconfigured();
    send_pauses = 1'b1;
    take_pauses = 1'b1;
    send_byte(SEQ_THIRD);
    send_byte(SEQ_FIRST);
    send_byte(SEQ_SECOND);
    send_byte(SEQ_THIRD);
    send_byte(8'h00);
  endtask

  // Hand-built table: duplicate ids, clamped count, zero count, invalid entry,
  // top entry with id 255; start inside a payload
  task automatic test_table_cases();
    wait_for_results();
    for (int i = 0; i < REG_COUNT; i++) staged_words[i] = '0;
    // e3: 0x33 count 0, e2: 0x22 count 7, e1: 0x11 count 2, e0: 0x11 count 4
    staged_words[0] = 48'h833_F22_A11_C11;
    // e4: 0x44 count 1, not valid
    staged_words[1] = 48'h000_000_000_144;
    // e31: 0xFF count 1
    staged_words[7] = 48'h9FF_000_000_000;
    load_table();
    send_pauses = 1'b0;
    send_byte(SEQ_FIRST);
    send_byte(SEQ_SECOND);
    send_byte(SEQ_THIRD);
    send_byte(8'h11);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h33);
    send_byte(8'h22);
    repeat (4) send_byte(8'hFF);
    send_byte(8'h55);
    // detector is part way in from the payload bytes
    send_byte(SEQ_SECOND);
    send_byte(SEQ_THIRD);
    send_byte(8'h44);
    send_byte(SEQ_FIRST);
    send_byte(SEQ_SECOND);
    send_byte(SEQ_THIRD);
    send_byte(8'h11);
    send_byte(SEQ_FIRST);
    send_byte(SEQ_SECOND);
    send_byte(SEQ_THIRD);
    send_byte(8'hFF);
    send_byte(8'h7E);
    send_byte(8'h00);
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      case (phase)
        1: for (int i = 0; i < REG_COUNT; i++) staged_words[i] = '1;
        2: stage_random_table(60);
        3: stage_random_table(15);
        4: stage_random_table(90);
        5: for (int i = 0; i < REG_COUNT; i++) staged_words[i] = '0;
        default: stage_random_table(80);
      endcase
      load_table();
      case (phase % 3)
        0: begin
          send_pauses = 1'b0;
          take_pauses = 1'b0;
        end
        1: begin
          send_pauses = 1'b1;
          take_pauses = 1'b1;
        end
        default: begin
          send_pauses = $urandom_range(0, 1);
          take_pauses = $urandom_range(0, 1);
        end
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 3) != 0) send_frame();
        else send_noise();
        if ($urandom_range(0, 39) == 0) wait_for_results();
      end
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    data_valid = 1'b0;
    data_byte  = '0;
    clear_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_unconfigured();
    test_table_cases();
    test_random_traffic();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_sensor_frame_deframer_top: clean");
    end else begin
      $display("tb_sensor_frame_deframer_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sfd_pkg.sv
src/sfd_table.sv
src/sfd_core.sv
src/sensor_frame_deframer_top.sv
tb/tb_sensor_frame_deframer_top.sv
